### rtl/htca_pkg.sv
// ----------------------------------------------------------------------------
// htca_pkg
// Shared types, constants and the microcode table of the humidity and
// temperature conversion and averaging block.
// ----------------------------------------------------------------------------
package htca_pkg;

	// default averaging window
	localparam int WINDOW_SIZE_DEF = 5;

	// temperature conversion: (raw - 3960) / 100 via reciprocal 5243 / 2^19
	localparam int T_OFFSET_RAW   = 3960;
	localparam int K_RECIP100     = 5243;
	localparam int RECIP100_SHIFT = 19;

	// humidity polynomial in signed Q.24
	localparam int  Q_FRAC       = 24;
	localparam int  K_LIN        = 679477;
	localparam int  K_SQ         = 47;
	localparam int  K_COMP_BASE  = 167772;
	localparam int  K_COMP_SLOPE = 1342;
	localparam longint K_OFFSET_Q = 64'd4 << Q_FRAC;
	localparam int  T_REF        = 25;

	// window average: |sum| * ceil(2^17 / window) >> 17
	localparam int AVG_SHIFT = 17;

	// datapath widths
	localparam int A_W    = 15;
	localparam int B_W    = 25;
	localparam int PROD_W = 40;
	localparam int SUM_W  = 12;
	localparam int BC_W   = 23;

	// step counter
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_TDIV  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TSET  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LIN   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_QUAD  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_COMP  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_ADD   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_HSET  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ACCUM = 4'd8;
	localparam logic [STEP_W-1:0] STEP_AVGT  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_AVGTS = 4'd10;
	localparam logic [STEP_W-1:0] STEP_AVGHS = 4'd11;
	localparam logic [STEP_W-1:0] STEP_OUT   = 4'd12;

	// multiplier operand a
	typedef enum logic [2:0] {
		A_ABSD     = 3'd0,
		A_H        = 3'd1,
		A_TREL     = 3'd2,
		A_ABS_TSUM = 3'd3,
		A_ABS_HSUM = 3'd4
	} a_sel_t;

	// multiplier operand b
	typedef enum logic [2:0] {
		B_RECIP100 = 3'd0,
		B_KSQ      = 3'd1,
		B_KSLOPE   = 3'd2,
		B_ACC      = 3'd3,
		B_BCOEF    = 3'd4,
		B_RECIPW   = 3'd5
	} b_sel_t;

	// accumulator operation
	typedef enum logic [1:0] {
		ACC_HOLD     = 2'd0,
		ACC_KLIN_SUB = 2'd1,
		ACC_PROD_OFS = 2'd2,
		ACC_ADD_PROD = 2'd3
	} acc_op_t;

	// register write select
	typedef enum logic [2:0] {
		WR_NONE  = 3'd0,
		WR_T     = 3'd1,
		WR_B     = 3'd2,
		WR_HUM   = 3'd3,
		WR_SUMS  = 3'd4,
		WR_AVG_T = 3'd5,
		WR_AVG_H = 3'd6
	} wr_sel_t;

	// jump condition
	typedef enum logic [2:0] {
		JC_NEVER    = 3'd0,
		JC_NO_INPUT = 3'd1,
		JC_NOT_DONE = 3'd2,
		JC_OUT_BUSY = 3'd3,
		JC_ALWAYS   = 3'd4
	} jc_t;

	// one control word
	typedef struct packed {
		logic              take_in;
		logic              load_out;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		acc_op_t           acc_op;
		wr_sel_t           wr_sel;
		jc_t               jc;
		logic [STEP_W-1:0] target;
		logic              last;
	} ctrl_t;

	// status back to the sequencer
	typedef struct packed {
		logic out_busy;
		logic window_end;
	} stat_t;

	// microcode table
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t cw;
		cw = '0;
		unique case (step)
			STEP_IDLE: begin
				cw.take_in = 1'b1;
				cw.jc      = JC_NO_INPUT;
				cw.target  = STEP_IDLE;
			end
			STEP_TDIV: begin
				cw.a_sel = A_ABSD;
				cw.b_sel = B_RECIP100;
			end
			STEP_TSET: begin
				cw.wr_sel = WR_T;
				cw.a_sel  = A_H;
				cw.b_sel  = B_KSQ;
			end
			STEP_LIN: begin
				cw.acc_op = ACC_KLIN_SUB;
				cw.a_sel  = A_H;
				cw.b_sel  = B_KSLOPE;
			end
			STEP_QUAD: begin
				cw.wr_sel = WR_B;
				cw.a_sel  = A_H;
				cw.b_sel  = B_ACC;
			end
			STEP_COMP: begin
				cw.acc_op = ACC_PROD_OFS;
				cw.a_sel  = A_TREL;
				cw.b_sel  = B_BCOEF;
			end
			STEP_ADD: begin
				cw.acc_op = ACC_ADD_PROD;
			end
			STEP_HSET: begin
				cw.wr_sel = WR_HUM;
			end
			STEP_ACCUM: begin
				cw.wr_sel = WR_SUMS;
				cw.jc     = JC_NOT_DONE;
				cw.target = STEP_OUT;
			end
			STEP_AVGT: begin
				cw.a_sel = A_ABS_TSUM;
				cw.b_sel = B_RECIPW;
			end
			STEP_AVGTS: begin
				cw.wr_sel = WR_AVG_T;
				cw.a_sel  = A_ABS_HSUM;
				cw.b_sel  = B_RECIPW;
			end
			STEP_AVGHS: begin
				cw.wr_sel = WR_AVG_H;
			end
			STEP_OUT: begin
				cw.load_out = 1'b1;
				cw.jc       = JC_OUT_BUSY;
				cw.target   = STEP_OUT;
				cw.last     = 1'b1;
			end
			default: begin
				cw.jc     = JC_ALWAYS;
				cw.target = STEP_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

### rtl/htca_sequencer.sv
// ----------------------------------------------------------------------------
// htca_sequencer
// Step counter with conditional jumps; reads one control word per step
// from the microcode table.
// ----------------------------------------------------------------------------
module htca_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  htca_pkg::stat_t stat,
	output htca_pkg::ctrl_t cw
);

	logic [htca_pkg::STEP_W-1:0] pc_q;
	logic                        jump;

	// control word of the current step
	assign cw = htca_pkg::ucode(pc_q);

	// jump condition decode
	always_comb begin
		unique case (cw.jc)
			htca_pkg::JC_NEVER:    jump = 1'b0;
			htca_pkg::JC_NO_INPUT: jump = !in_valid;
			htca_pkg::JC_NOT_DONE: jump = !stat.window_end;
			htca_pkg::JC_OUT_BUSY: jump = stat.out_busy;
			htca_pkg::JC_ALWAYS:   jump = 1'b1;
			default:               jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= htca_pkg::STEP_IDLE;
		end else if (jump) begin
			pc_q <= cw.target;
		end else if (cw.last) begin
			pc_q <= htca_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	// an accepted item always starts the temperature step
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.take_in && in_valid) |=> (pc_q == htca_pkg::STEP_TDIV))
		else $error("sequencer did not start after taking an item");

endmodule

### rtl/htca_datapath.sv
// ----------------------------------------------------------------------------
// htca_datapath
// Shared multiplier, accumulator, result registers, window sums and the
// output register, all steered by the control word.
// ----------------------------------------------------------------------------
module htca_datapath #(
	parameter int WINDOW_SIZE = htca_pkg::WINDOW_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  htca_pkg::ctrl_t   cw,
	output htca_pkg::stat_t   stat,
	input  logic              in_valid,
	input  logic [13:0]       raw_temperature,
	input  logic [11:0]       raw_humidity,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] temperature_c,
	output logic signed [8:0] humidity_pct,
	output logic              average_valid,
	output logic signed [7:0] average_temperature,
	output logic signed [8:0] average_humidity
);

	localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
	localparam int RECIP_W = ((1 << htca_pkg::AVG_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SIZE - 1);
	localparam int SW = htca_pkg::SUM_W;

	// sample registers
	logic                           d_neg_q;
	logic [13:0]                    absd_q;
	logic [11:0]                    rh_q;
	// arithmetic
	logic signed [htca_pkg::A_W-1:0]    a_op;
	logic signed [htca_pkg::B_W-1:0]    b_op;
	logic signed [htca_pkg::PROD_W-1:0] prod_q;
	logic signed [htca_pkg::PROD_W-1:0] acc_q;
	logic signed [htca_pkg::PROD_W-1:0] acc_rnd;
	logic [htca_pkg::BC_W-1:0]          b_q;
	logic [8:0]                         trel;
	logic [7:0]                         tq;
	// results
	logic [7:0]                     t_q;
	logic [8:0]                     hum_q;
	logic [7:0]                     avg_t_q;
	logic [8:0]                     avg_h_q;
	// window state
	logic [SW-1:0]                  tsum_q;
	logic [SW-1:0]                  hsum_q;
	logic [SW-1:0]                  tsum_mag;
	logic [SW-1:0]                  hsum_mag;
	logic [SW-1:0]                  avg_mag;
	logic [SW-1:0]                  avg_val;
	logic [CNT_W-1:0]               sample_count_q;
	logic                           done_q;
	logic                           window_end;
	// handshake
	logic                           in_take;
	logic                           out_load;
	logic                           out_valid_q;
	logic [7:0]                     temp_out_q;
	logic [8:0]                     hum_out_q;
	logic                           avg_valid_q;
	logic [7:0]                     avg_t_out_q;
	logic [8:0]                     avg_h_out_q;

	assign in_take         = cw.take_in && in_valid;
	assign stat.out_busy   = out_valid_q && !out_ready;
	assign out_load        = cw.load_out && !stat.out_busy;
	assign window_end      = (sample_count_q == CNT_LAST);
	assign stat.window_end = window_end;

	// operand helpers
	assign trel     = {t_q[7], t_q} - 9'(htca_pkg::T_REF);
	assign tsum_mag = tsum_q[SW-1] ? (~tsum_q + 1'b1) : tsum_q;
	assign hsum_mag = hsum_q[SW-1] ? (~hsum_q + 1'b1) : hsum_q;
	assign tq       = prod_q[htca_pkg::RECIP100_SHIFT +: 8];
	assign avg_mag  = prod_q[htca_pkg::AVG_SHIFT +: SW];

	// operand a select
	always_comb begin
		unique case (cw.a_sel)
			htca_pkg::A_ABSD:     a_op = {1'b0, absd_q};
			htca_pkg::A_H:        a_op = {3'b000, rh_q};
			htca_pkg::A_TREL:     a_op = {{6{trel[8]}}, trel};
			htca_pkg::A_ABS_TSUM: a_op = {3'b000, tsum_mag};
			htca_pkg::A_ABS_HSUM: a_op = {3'b000, hsum_mag};
			default:              a_op = '0;
		endcase
	end

	// operand b select
	always_comb begin
		unique case (cw.b_sel)
			htca_pkg::B_RECIP100: b_op = htca_pkg::B_W'(htca_pkg::K_RECIP100);
			htca_pkg::B_KSQ:      b_op = htca_pkg::B_W'(htca_pkg::K_SQ);
			htca_pkg::B_KSLOPE:   b_op = htca_pkg::B_W'(htca_pkg::K_COMP_SLOPE);
			htca_pkg::B_ACC:      b_op = {1'b0, acc_q[23:0]};
			htca_pkg::B_BCOEF:    b_op = {2'b00, b_q};
			htca_pkg::B_RECIPW:   b_op = htca_pkg::B_W'(RECIP_W);
			default:              b_op = '0;
		endcase
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= htca_pkg::PROD_W'(a_op * b_op);
	end

	// accumulator
	always_ff @(posedge clk) begin
		case (cw.acc_op)
			htca_pkg::ACC_KLIN_SUB: acc_q <= htca_pkg::PROD_W'(htca_pkg::K_LIN) - prod_q;
			htca_pkg::ACC_PROD_OFS: acc_q <= prod_q - htca_pkg::PROD_W'(htca_pkg::K_OFFSET_Q);
			htca_pkg::ACC_ADD_PROD: acc_q <= acc_q + prod_q;
			default:                acc_q <= acc_q;
		endcase
	end

	// truncate toward zero on the Q.24 result
	assign acc_rnd = acc_q + (acc_q[htca_pkg::PROD_W-1] ?
		htca_pkg::PROD_W'((64'd1 << htca_pkg::Q_FRAC) - 64'd1) : '0);

	// sign applied to the window average magnitude
	always_comb begin
		if (cw.wr_sel == htca_pkg::WR_AVG_H) begin
			avg_val = hsum_q[SW-1] ? (~avg_mag + 1'b1) : avg_mag;
		end else begin
			avg_val = tsum_q[SW-1] ? (~avg_mag + 1'b1) : avg_mag;
		end
	end

	// input capture and result registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			d_neg_q <= (raw_temperature < 14'(htca_pkg::T_OFFSET_RAW));
			absd_q  <= (raw_temperature < 14'(htca_pkg::T_OFFSET_RAW)) ?
				(14'(htca_pkg::T_OFFSET_RAW) - raw_temperature) :
				(raw_temperature - 14'(htca_pkg::T_OFFSET_RAW));
			rh_q    <= raw_humidity;
			avg_t_q <= '0;
			avg_h_q <= '0;
		end else begin
			case (cw.wr_sel)
				htca_pkg::WR_T:     t_q     <= d_neg_q ? (~tq + 1'b1) : tq;
				htca_pkg::WR_B:     b_q     <= prod_q[htca_pkg::BC_W-1:0]
					+ htca_pkg::BC_W'(htca_pkg::K_COMP_BASE);
				htca_pkg::WR_HUM:   hum_q   <= acc_rnd[htca_pkg::Q_FRAC +: 9];
				htca_pkg::WR_AVG_T: avg_t_q <= avg_val[7:0];
				htca_pkg::WR_AVG_H: avg_h_q <= avg_val[8:0];
				default: ;
			endcase
		end
	end

	// window sums and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsum_q         <= '0;
			hsum_q         <= '0;
			sample_count_q <= '0;
			done_q         <= 1'b0;
		end else if (cw.wr_sel == htca_pkg::WR_SUMS) begin
			tsum_q         <= tsum_q + {{(SW-8){t_q[7]}}, t_q};
			hsum_q         <= hsum_q + {{(SW-9){hum_q[8]}}, hum_q};
			sample_count_q <= window_end ? '0 : sample_count_q + 1'b1;
			done_q         <= window_end;
		end else if (cw.wr_sel == htca_pkg::WR_AVG_H) begin
			tsum_q <= '0;
			hsum_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			temp_out_q  <= t_q;
			hum_out_q   <= hum_q;
			avg_valid_q <= done_q;
			avg_t_out_q <= avg_t_q;
			avg_h_out_q <= avg_h_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign temperature_c       = temp_out_q;
	assign humidity_pct        = hum_out_q;
	assign average_valid       = avg_valid_q;
	assign average_temperature = avg_t_out_q;
	assign average_humidity    = avg_h_out_q;

	// sample count stays inside the window
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_count_q <= CNT_LAST)
		else $error("sample count ran past the window");

	// averages read zero unless a window completes
	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !avg_valid_q) |-> (avg_t_out_q == '0 && avg_h_out_q == '0))
		else $error("nonzero average outside a window end");

	// converted temperature stays in the sensor range
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($signed(temp_out_q) >= -8'sd40 && $signed(temp_out_q) <= 8'sd124))
		else $error("temperature conversion out of range");

endmodule

### rtl/humidity_temp_convert_average_top.sv
// A result passes through the conversion steps and, at a window end, the averaging
// steps before it is loaded into the output register; a new item is taken only in
// the idle step. The one shared multiplier is used once per microcode step.
// A waiting result holds the sequencer in its output step until it is taken.
// Reset (arst_n low, asynchronous) clears the step counter, sums, count and out_valid.
// ----------------------------------------------------------------------------
// humidity_temp_convert_average_top
// Converts raw temperature and humidity counts, compensates humidity and
// gives window averages; a microcoded sequencer drives a shared datapath.
// ----------------------------------------------------------------------------
module humidity_temp_convert_average_top #(
	parameter int WINDOW_SIZE = htca_pkg::WINDOW_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [13:0]       raw_temperature,
	input  logic [11:0]       raw_humidity,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] temperature_c,
	output logic signed [8:0] humidity_pct,
	output logic              average_valid,
	output logic signed [7:0] average_temperature,
	output logic signed [8:0] average_humidity
);

	htca_pkg::ctrl_t cw;
	htca_pkg::stat_t stat;

	// item taken only in the idle step
	assign in_ready = cw.take_in;

	// step counter and microcode
	htca_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cw       (cw)
	);

	// arithmetic and output register
	htca_datapath #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cw                  (cw),
		.stat                (stat),
		.in_valid            (in_valid),
		.raw_temperature     (raw_temperature),
		.raw_humidity        (raw_humidity),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.temperature_c       (temperature_c),
		.humidity_pct        (humidity_pct),
		.average_valid       (average_valid),
		.average_temperature (average_temperature),
		.average_humidity    (average_humidity)
	);

endmodule

### tb/humidity_temp_convert_average_top_tb.sv
// ----------------------------------------------------------------------------
// humidity_temp_convert_average_top_tb
// Drives raw temperature and humidity counts through the converter with
// random gaps on both handshakes. An in-bench model predicts each reading
// and the five-sample window averages, and every result is checked in order.
// ----------------------------------------------------------------------------
module humidity_temp_convert_average_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LEN   = 5;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_TIME  = 30;
	localparam int RANDOM_ITEMS = 1130;
	localparam int MAX_PRINTED  = 50;

	// temperature conversion and humidity polynomial in Q.24
	localparam int     RAW_T_ZERO   = 3960;
	localparam int     RAW_T_STEP   = 100;
	localparam longint HUM_ONE_Q24  = 64'sd1 <<< 24;
	localparam longint HUM_LIN_Q24  = 64'sd679477;
	localparam longint HUM_SQ_Q24   = 64'sd47;
	localparam longint COMP_BASE_Q  = 64'sd167772;
	localparam longint COMP_SLOPE_Q = 64'sd1342;
	localparam longint HUM_OFS_Q24  = 64'sd4 <<< 24;
	localparam int     T_NOMINAL    = 25;

	typedef struct {
		int temp;
		int hum;
		int avg_valid;
		int avg_temp;
		int avg_hum;
	} reading_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [13:0]       raw_temperature;
	logic [11:0]       raw_humidity;
	logic              out_valid;
	logic              out_ready;
	logic signed [7:0] temperature_c;
	logic signed [8:0] humidity_pct;
	logic              average_valid;
	logic signed [7:0] average_temperature;
	logic signed [8:0] average_humidity;

	reading_t pending_readings[$];
	int       error_count;
	int       readings_seen;
	int       cycle_count;
	bit       tx_steady;

	// window state of the in-bench model
	int temp_window_sum;
	int hum_window_sum;
	int window_fill;

	humidity_temp_convert_average_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.raw_temperature     (raw_temperature),
		.raw_humidity        (raw_humidity),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.temperature_c       (temperature_c),
		.humidity_pct        (humidity_pct),
		.average_valid       (average_valid),
		.average_temperature (average_temperature),
		.average_humidity    (average_humidity)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int wrap_sum12(int v);
		logic signed [11:0] w;
		w = v[11:0];
		return w;
	endfunction

	function automatic int celsius_of(logic [13:0] raw);
		int d;
		d = raw;
		d = d - RAW_T_ZERO;
		return d / RAW_T_STEP;
	endfunction

	function automatic int rel_humidity_of(logic [11:0] raw, int t);
		longint h;
		longint acc;
		h = raw;
		acc = HUM_LIN_Q24 * h - HUM_OFS_Q24 - HUM_SQ_Q24 * h * h
			+ longint'(t - T_NOMINAL) * (COMP_BASE_Q + COMP_SLOPE_Q * h);
		return int'(acc / HUM_ONE_Q24);
	endfunction

	// model one accepted item and queue the reading it must produce
	task automatic convert_reading(input logic [13:0] rt, input logic [11:0] rh);
		reading_t r;
		r.temp = celsius_of(rt);
		r.hum  = rel_humidity_of(rh, r.temp);
		r.avg_valid = 0;
		r.avg_temp  = 0;
		r.avg_hum   = 0;
		temp_window_sum = wrap_sum12(temp_window_sum + r.temp);
		hum_window_sum  = wrap_sum12(hum_window_sum + r.hum);
		window_fill++;
		if (window_fill >= WINDOW_LEN) begin
			r.avg_valid = 1;
			r.avg_temp  = temp_window_sum / WINDOW_LEN;
			r.avg_hum   = hum_window_sum / WINDOW_LEN;
			temp_window_sum = 0;
			hum_window_sum  = 0;
			window_fill     = 0;
		end
		pending_readings.push_back(r);
	endtask

	task automatic flag_error(input string what);
		if (error_count < MAX_PRINTED)
			$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			flag_error($sformatf("reading %0d %s: got %0d, expected %0d",
				readings_seen, name, got, want));
	endtask

	// send one item; returns at the edge where it is accepted, valid still high
	task automatic send_sample(input logic [13:0] rt, input logic [11:0] rh);
		int gap;
		gap = tx_steady ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		raw_temperature <= rt;
		raw_humidity    <= rh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		convert_reading(rt, rh);
	endtask

	// stop sending and let every queued reading come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	// temperature extremes and the truncation around zero degrees
	task automatic test_temperature_edges();
		send_sample(14'd0, 12'd1500);
		send_sample(14'd16383, 12'd1500);
		send_sample(14'd3960, 12'd2000);
		send_sample(14'd3959, 12'd2000);
		send_sample(14'd3861, 12'd2000);
		send_sample(14'd3860, 12'd2000);
		send_sample(14'd4060, 12'd2000);
		wait_drained();
	endtask

	// humidity extremes at both temperature extremes
	task automatic test_humidity_edges();
		send_sample(14'd0, 12'd0);
		send_sample(14'd0, 12'd4095);
		send_sample(14'd16383, 12'd0);
		send_sample(14'd16383, 12'd4095);
		wait_drained();
	endtask

	// negative window sums that do not divide evenly, then a window of maxima
	task automatic test_window_averages();
		// start on a window boundary
		while (window_fill != 0)
			send_sample(14'd3960, 12'd2000);
		send_sample(14'd3860, 12'd0);
		send_sample(14'd3860, 12'd0);
		send_sample(14'd3960, 12'd10);
		send_sample(14'd3860, 12'd0);
		send_sample(14'd3860, 12'd0);
		send_sample(14'd16383, 12'd4095);
		send_sample(14'd16383, 12'd4095);
		send_sample(14'd16383, 12'd4095);
		send_sample(14'd16383, 12'd4095);
		send_sample(14'd16383, 12'd4095);
		wait_drained();
	endtask

	// random counts, biased now and then toward the corners
	task automatic test_random_readings();
		logic [13:0] rt;
		logic [11:0] rh;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 99) == 0)
				tx_steady = !tx_steady;
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 5))
					0: rt = 14'd0;
					1: rt = 14'd16383;
					2: rt = 14'd3960;
					3: rt = 14'd3959;
					4: rt = 14'd3861;
					default: rt = 14'd3860;
				endcase
			end else begin
				rt = 14'($urandom_range(0, 16383));
			end
			if ($urandom_range(0, 9) == 0)
				rh = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
			else
				rh = 12'($urandom_range(0, 4095));
			send_sample(rt, rh);
			if ($urandom_range(0, 199) == 0)
				wait_drained();
		end
		tx_steady = 1'b0;
		wait_drained();
	endtask

	// receiver back-pressure with stretches of none
	initial begin : sink_pacing
		int stall;
		bit steady;
		stall = 0;
		steady = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				steady = !steady;
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				stall = idle_cycles();
				out_ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	// compare each accepted result with the oldest queued reading
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				flag_error("result with no reading pending");
			end else begin
				want = pending_readings.pop_front();
				check_field("temperature_c", temperature_c, want.temp);
				check_field("humidity_pct", humidity_pct, want.hum);
				check_field("average_valid", average_valid, want.avg_valid);
				check_field("average_temperature", average_temperature, want.avg_temp);
				check_field("average_humidity", average_humidity, want.avg_hum);
			end
			readings_seen++;
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		error_count     = 0;
		readings_seen   = 0;
		temp_window_sum = 0;
		hum_window_sum  = 0;
		window_fill     = 0;
		tx_steady       = 1'b0;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		raw_temperature <= '0;
		raw_humidity    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_temperature_edges();
		test_humidity_edges();
		test_window_averages();
		test_random_readings();

		repeat (SETTLE_TIME) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
